@@ rtl/rgb_to_ansi16_quantizer_core_assert.svh @@
// Assertion macros for the quantizer core.
`ifndef RGB_TO_ANSI16_QUANTIZER_CORE_ASSERT_SVH
`define RGB_TO_ANSI16_QUANTIZER_CORE_ASSERT_SVH

// Implication checked on the same edge.
`define RTAQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the next edge.
`define RTAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rtaq_pkg.sv @@
`timescale 1ns / 1ps

package rtaq_pkg;

  typedef logic [7:0] chan_t;
  typedef logic [3:0] cidx_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned Latency = 5;

  localparam logic [CfgIdxW-1:0] CFG_WHITE_MIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIGHT_GRAY_MIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLACK_MAX      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DARK_MAX       = 3'd3;

  localparam chan_t WHITE_MIN_RST      = 8'd230;
  localparam chan_t LIGHT_GRAY_MIN_RST = 8'd133;
  localparam chan_t BLACK_MAX_RST      = 8'd38;
  localparam chan_t DARK_MAX_RST       = 8'd178;

  localparam cidx_t IDX_BLACK   = 4'h0;
  localparam cidx_t IDX_LGRAY   = 4'h7;
  localparam cidx_t IDX_DGRAY   = 4'h8;
  localparam cidx_t IDX_RED     = 4'h9;
  localparam cidx_t IDX_GREEN   = 4'ha;
  localparam cidx_t IDX_YELLOW  = 4'hb;
  localparam cidx_t IDX_BLUE    = 4'hc;
  localparam cidx_t IDX_MAGENTA = 4'hd;
  localparam cidx_t IDX_CYAN    = 4'he;
  localparam cidx_t IDX_WHITE   = 4'hf;

  localparam logic [3:0] SECT_COUNT = 4'd12;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } maxch_e;

  typedef struct packed {
    chan_t white_min;
    chan_t light_gray_min;
    chan_t black_max;
    chan_t dark_max;
  } cfg_t;

  typedef struct packed {
    chan_t  r;
    chan_t  g;
    chan_t  b;
    chan_t  mx;
    chan_t  d;
    maxch_e maxch;
  } mm_t;

  typedef struct packed {
    chan_t       r;
    chan_t       g;
    chan_t       b;
    chan_t       mx;
    chan_t       d;
    logic [16:0] x;
    logic        lowsat;
  } hue_t;

  typedef struct packed {
    chan_t      r;
    chan_t      g;
    chan_t      b;
    chan_t      mx;
    logic [3:0] sect;
    logic       lowsat;
  } sec_t;

  typedef struct packed {
    chan_t             mx;
    logic              lowsat;
    logic              boundary;
    cidx_t             first;
    cidx_t             second;
    logic signed [8:0] da0;
    logic signed [8:0] da1;
    logic signed [8:0] db0;
    logic signed [8:0] db1;
  } diff_t;

  function automatic logic [23:0] pal_rgb(input cidx_t idx);
    logic [23:0] rgb;
    case (idx)
      4'h0:    rgb = 24'h000000;
      4'h1:    rgb = 24'hb21818;
      4'h2:    rgb = 24'h18b218;
      4'h3:    rgb = 24'hb26818;
      4'h4:    rgb = 24'h1818b2;
      4'h5:    rgb = 24'hb218b2;
      4'h6:    rgb = 24'h18b2b2;
      4'h7:    rgb = 24'hb2b2b2;
      4'h8:    rgb = 24'h686868;
      4'h9:    rgb = 24'hff5454;
      4'ha:    rgb = 24'h54ff54;
      4'hb:    rgb = 24'hffff54;
      4'hc:    rgb = 24'h5454ff;
      4'hd:    rgb = 24'hff54ff;
      4'he:    rgb = 24'h54ffff;
      default: rgb = 24'hffffff;
    endcase
    return rgb;
  endfunction

  // bright color of pure sector pair k: red, yellow, green, cyan, blue, magenta
  function automatic cidx_t pure_color(input logic [2:0] k);
    cidx_t c;
    case (k)
      3'd0:    c = IDX_RED;
      3'd1:    c = IDX_YELLOW;
      3'd2:    c = IDX_GREEN;
      3'd3:    c = IDX_CYAN;
      3'd4:    c = IDX_BLUE;
      3'd5:    c = IDX_MAGENTA;
      default: c = IDX_RED;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/rtaq_hue.sv @@
`timescale 1ns / 1ps

module rtaq_hue import rtaq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  chan_t red_i,
  input  chan_t green_i,
  input  chan_t blue_i,
  output logic  valid_o,
  output hue_t  item_o
);

  logic  mm_valid_q;
  mm_t   mm_d, mm_q;
  logic  hue_valid_q;
  hue_t  hue_d, hue_q;

  chan_t mx, mn;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    mm_d.r  = red_i;
    mm_d.g  = green_i;
    mm_d.b  = blue_i;
    mm_d.mx = mx;
    mm_d.d  = mx - mn;
    if (red_i == mx) begin
      mm_d.maxch = MAX_RED;
    end else if (green_i == mx) begin
      mm_d.maxch = MAX_GREEN;
    end else begin
      mm_d.maxch = MAX_BLUE;
    end
  end

  localparam logic signed [18:0] K60  = 19'sd60;
  localparam logic signed [18:0] K120 = 19'sd120;
  localparam logic signed [18:0] K240 = 19'sd240;
  localparam logic signed [18:0] K360 = 19'sd360;

  logic signed [18:0] sr, sg, sb, sd, xs;
  logic [10:0]        d5;

  always_comb begin
    sr = $signed({11'b0, mm_q.r});
    sg = $signed({11'b0, mm_q.g});
    sb = $signed({11'b0, mm_q.b});
    sd = $signed({11'b0, mm_q.d});
    case (mm_q.maxch)
      MAX_RED: begin
        xs = K60 * (sg - sb);
        if (xs < 0) xs = xs + K360 * sd;
      end
      MAX_GREEN: xs = K60 * (sb - sr) + K120 * sd;
      default:   xs = K60 * (sr - sg) + K240 * sd;
    endcase
    d5 = {1'b0, mm_q.d, 2'b00} + {3'b0, mm_q.d};
    hue_d.r      = mm_q.r;
    hue_d.g      = mm_q.g;
    hue_d.b      = mm_q.b;
    hue_d.mx     = mm_q.mx;
    hue_d.d      = mm_q.d;
    hue_d.x      = xs[16:0];
    hue_d.lowsat = (d5 <= {3'b0, mm_q.mx});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_valid_q  <= 1'b0;
      hue_valid_q <= 1'b0;
    end else begin
      mm_valid_q  <= valid_i;
      hue_valid_q <= mm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mm_q  <= mm_d;
    hue_q <= hue_d;
  end

  assign valid_o = hue_valid_q;
  assign item_o  = hue_q;

endmodule

@@ rtl/rtaq_sector.sv @@
`timescale 1ns / 1ps

module rtaq_sector import rtaq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  hue_t  item_i,
  output logic  valid_o,
  output diff_t item_o
);

  logic  sec_valid_q;
  sec_t  sec_d, sec_q;
  logic  diff_valid_q;
  diff_t diff_d, diff_q;

  logic [16:0] thr;
  logic [3:0]  cnt;
  logic        wrap;

  // bound k sits at (15 + 30k) degrees; hue*d is compared against bound*d
  always_comb begin
    cnt  = '0;
    wrap = 1'b0;
    for (int k = 0; k < int'(SECT_COUNT); k++) begin
      thr = 17'(15 + 30 * k) * {9'b0, item_i.d};
      if (item_i.x >= thr) begin
        if (k == int'(SECT_COUNT) - 1) wrap = 1'b1;
        else cnt = cnt + 4'd1;
      end
    end
    sec_d.r      = item_i.r;
    sec_d.g      = item_i.g;
    sec_d.b      = item_i.b;
    sec_d.mx     = item_i.mx;
    sec_d.lowsat = item_i.lowsat;
    sec_d.sect   = wrap ? 4'd0 : cnt;
  end

  logic [2:0] k2;
  chan_t      a0, a1;
  logic [1:0] c0, c1;
  logic [23:0] pf, ps;

  function automatic chan_t rgb_chan(input logic [23:0] rgb, input logic [1:0] ch);
    chan_t v;
    case (ch)
      2'd0:    v = rgb[23:16];
      2'd1:    v = rgb[15:8];
      default: v = rgb[7:0];
    endcase
    return v;
  endfunction

  always_comb begin
    k2 = sec_q.sect[3:1] + 3'd1;
    if (k2 == 3'd6) k2 = 3'd0;
    diff_d.first    = pure_color(sec_q.sect[3:1]);
    diff_d.second   = pure_color(k2);
    diff_d.boundary = sec_q.sect[0];
    diff_d.mx       = sec_q.mx;
    diff_d.lowsat   = sec_q.lowsat;
    case (sec_q.sect[3:2])
      2'd0: begin
        c0 = 2'd0; c1 = 2'd1; a0 = sec_q.r; a1 = sec_q.g;
      end
      2'd1: begin
        c0 = 2'd1; c1 = 2'd2; a0 = sec_q.g; a1 = sec_q.b;
      end
      2'd2: begin
        c0 = 2'd2; c1 = 2'd0; a0 = sec_q.b; a1 = sec_q.r;
      end
      default: begin
        c0 = 2'd0; c1 = 2'd1; a0 = sec_q.r; a1 = sec_q.g;
      end
    endcase
    pf = pal_rgb(diff_d.first);
    ps = pal_rgb(diff_d.second);
    diff_d.da0 = $signed({1'b0, a0}) - $signed({1'b0, rgb_chan(pf, c0)});
    diff_d.da1 = $signed({1'b0, a1}) - $signed({1'b0, rgb_chan(pf, c1)});
    diff_d.db0 = $signed({1'b0, a0}) - $signed({1'b0, rgb_chan(ps, c0)});
    diff_d.db1 = $signed({1'b0, a1}) - $signed({1'b0, rgb_chan(ps, c1)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_valid_q  <= 1'b0;
      diff_valid_q <= 1'b0;
    end else begin
      sec_valid_q  <= valid_i;
      diff_valid_q <= sec_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= sec_d;
    diff_q <= diff_d;
  end

  assign valid_o = diff_valid_q;
  assign item_o  = diff_q;

endmodule

@@ rtl/rtaq_pick.sv @@
`timescale 1ns / 1ps

module rtaq_pick import rtaq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  input  diff_t item_i,
  output logic  done_o,
  output cidx_t color_index_o,
  output chan_t red_out_o,
  output chan_t green_out_o,
  output chan_t blue_out_o
);

  logic              done_q;
  cidx_t             idx_d, idx_q;
  logic [23:0]       rgb_d, rgb_q;
  logic signed [17:0] pa0, pa1, pb0, pb1;
  logic [17:0]       dist_a, dist_b;
  cidx_t             base;

  always_comb begin
    pa0    = item_i.da0 * item_i.da0;
    pa1    = item_i.da1 * item_i.da1;
    pb0    = item_i.db0 * item_i.db0;
    pb1    = item_i.db1 * item_i.db1;
    dist_a = {1'b0, pa0[16:0]} + {1'b0, pa1[16:0]};
    dist_b = {1'b0, pb0[16:0]} + {1'b0, pb1[16:0]};
    if (!item_i.boundary || (dist_a < dist_b)) begin
      base = item_i.first;
    end else begin
      base = item_i.second;
    end
    if (item_i.lowsat) begin
      if (item_i.mx >= cfg_i.white_min) begin
        idx_d = IDX_WHITE;
      end else if (item_i.mx >= cfg_i.light_gray_min) begin
        idx_d = IDX_LGRAY;
      end else if (item_i.mx > cfg_i.black_max) begin
        idx_d = IDX_DGRAY;
      end else begin
        idx_d = IDX_BLACK;
      end
    end else if (item_i.mx <= cfg_i.dark_max) begin
      idx_d = (item_i.mx <= cfg_i.black_max) ? IDX_BLACK : {1'b0, base[2:0]};
    end else begin
      idx_d = base;
    end
    rgb_d = pal_rgb(idx_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rgb_q <= rgb_d;
  end

  assign done_o        = done_q;
  assign color_index_o = idx_q;
  assign red_out_o     = rgb_q[23:16];
  assign green_out_o   = rgb_q[15:8];
  assign blue_out_o    = rgb_q[7:0];

endmodule

@@ rtl/rgb_to_ansi16_quantizer_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// pixel     in   start_i / busy_o       red_in_i, green_in_i, blue_in_i
// result    out  done_o (one cycle)     color_index_o, red_out_o, green_out_o, blue_out_o
// config    in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Five register stages: min/max, hue, sector, channel differences, pick.
// One pixel per clock; the result strobes done_o once the request has passed through every stage.
// busy_o stays low: the pipeline never holds, as results cannot be refused.
// Reset clears stage valid bits and loads the threshold registers.
`include "rgb_to_ansi16_quantizer_core_assert.svh"

module rgb_to_ansi16_quantizer_core import rtaq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  chan_t              red_in_i,
  input  chan_t              green_in_i,
  input  chan_t              blue_in_i,
  output logic               done_o,
  output cidx_t              color_index_o,
  output chan_t              red_out_o,
  output chan_t              green_out_o,
  output chan_t              blue_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  chan_t              cfg_data_i
);

  cfg_t  cfg_d, cfg_q;
  logic  accept;
  logic  hue_valid;
  hue_t  hue_item;
  logic  diff_valid;
  diff_t diff_item;
  logic  out_is_gray;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WHITE_MIN:      cfg_d.white_min      = cfg_data_i;
        CFG_LIGHT_GRAY_MIN: cfg_d.light_gray_min = cfg_data_i;
        CFG_BLACK_MAX:      cfg_d.black_max      = cfg_data_i;
        CFG_DARK_MAX:       cfg_d.dark_max       = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.white_min      <= WHITE_MIN_RST;
      cfg_q.light_gray_min <= LIGHT_GRAY_MIN_RST;
      cfg_q.black_max      <= BLACK_MAX_RST;
      cfg_q.dark_max       <= DARK_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rtaq_hue u_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .valid_o (hue_valid),
    .item_o  (hue_item)
  );

  rtaq_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hue_valid),
    .item_i  (hue_item),
    .valid_o (diff_valid),
    .item_o  (diff_item)
  );

  rtaq_pick u_pick (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (diff_valid),
    .item_i        (diff_item),
    .done_o        (done_o),
    .color_index_o (color_index_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o)
  );

  assign out_is_gray = color_index_o inside {IDX_BLACK, IDX_LGRAY, IDX_DGRAY, IDX_WHITE};

  `RTAQ_ASSERT_SAME(a_done_has_request, done_o, $past(accept, Latency), "result without request")
  `RTAQ_ASSERT_NEXT(a_lowsat_gray, diff_valid && diff_item.lowsat, done_o && out_is_gray, "low saturation pixel gave a hue")
  `RTAQ_ASSERT_NEXT(a_stage_to_done, diff_valid, done_o, "stage valid lost before result")

endmodule
